FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define ASSERT_HOLDS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: src/cssq_pkg.sv
// ----------------------------------------------------------------------------
// cssq_pkg
// types and constants of the converter soft-start sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cssq_pkg;

	localparam int REF_FRAC_BITS = 24;
	localparam int REF_W         = REF_FRAC_BITS + 1;
	localparam int TIMER_W       = 16;
	localparam int STABLE_W      = 8;
	localparam int STEP_W        = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_PREPARE_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STABLE_TICKS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_TICKS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP     = 2'd3;

	localparam logic [7:0]        PREPARE_TICKS_RST = 8'd20;
	localparam logic [7:0]        STABLE_TICKS_RST  = 8'd50;
	localparam logic [15:0]       STOP_TICKS_RST    = 16'd10000;
	localparam logic [STEP_W-1:0] RAMP_STEP_RST     = 16'd419;

	typedef enum logic [2:0] {
		PH_INIT      = 3'd0,
		PH_STANDBY   = 3'd1,
		PH_PREPARE   = 3'd2,
		PH_SOFTSTART = 3'd3,
		PH_RUN       = 3'd4,
		PH_STOPPING  = 3'd5,
		PH_FAULT     = 3'd6
	} phase_t;

	typedef struct packed {
		logic             enable;
		logic             fault_active;
		logic [REF_W-1:0] target_ref;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       phase;
		logic             loop_on;
		logic [REF_W-1:0] ref_value;
	} out_item_t;

endpackage

`default_nettype wire

FILE: src/converter_softstart_sequencer_unit.sv
// ----------------------------------------------------------------------------
// converter_softstart_sequencer_unit
// soft-start sequencer: one slow tick in, one phase / loop / reference out
// ----------------------------------------------------------------------------
//  channel   signals                         direction
//  in        in_valid in_ready in_data        tick transfer into the block
//  out       out_valid out_ready out_data     result transfer out of the block
//  cfg       cfg_wen cfg_index cfg_wdata      register write, no wait
//
//  a tick passes through the input register and then the result register
//  one tick per cycle sustained while out_ready is high
//  the sequencer state updates as a tick moves into the result register
//  a stalled result holds both registers, in_ready drops only when both are full
//  reset clears the sequencer to init and the registers to their defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module converter_softstart_sequencer_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire cssq_pkg::in_item_t                   in_data,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output cssq_pkg::out_item_t                       out_data,
	input  wire logic                                 cfg_wen,
	input  wire logic [cssq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [cssq_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	import cssq_pkg::*;

	logic [7:0]          prepare_ticks_q;
	logic [7:0]          stable_ticks_q;
	logic [15:0]         stop_ticks_q;
	logic [STEP_W-1:0]   ramp_step_q;

	logic                valid_s1;
	in_item_t            item_s1;
	logic                out_valid_q;
	out_item_t           out_data_q;
	logic                advance;

	phase_t              phase_q, phase_d;
	logic [TIMER_W-1:0]  timer_q, timer_d, timer_inc;
	logic [STABLE_W-1:0] stable_q, stable_d, stable_inc;
	logic [REF_W-1:0]    ref_q, ref_d, gap, ref_toward, tgt;
	logic                loop_q, loop_d;
	logic                near;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prepare_ticks_q <= PREPARE_TICKS_RST;
			stable_ticks_q  <= STABLE_TICKS_RST;
			stop_ticks_q    <= STOP_TICKS_RST;
			ramp_step_q     <= RAMP_STEP_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_PREPARE_TICKS: prepare_ticks_q <= cfg_wdata[7:0];
				CFG_STABLE_TICKS:  stable_ticks_q  <= cfg_wdata[7:0];
				CFG_STOP_TICKS:    stop_ticks_q    <= cfg_wdata[15:0];
				CFG_RAMP_STEP:     ramp_step_q     <= cfg_wdata[STEP_W-1:0];
				default:           ;
			endcase
		end
	end

	// handshake
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// next sequencer state
	assign tgt = item_s1.target_ref;

	always_comb begin
		timer_inc  = (timer_q == {TIMER_W{1'b1}}) ? timer_q : timer_q + TIMER_W'(1);
		stable_inc = (stable_q == {STABLE_W{1'b1}}) ? stable_q : stable_q + STABLE_W'(1);
		gap        = (ref_q >= tgt) ? (ref_q - tgt) : (tgt - ref_q);
		near       = gap <= {{(REF_W-STEP_W){1'b0}}, ramp_step_q};
		if (near) begin
			ref_toward = tgt;
		end else if (ref_q < tgt) begin
			ref_toward = ref_q + {{(REF_W-STEP_W){1'b0}}, ramp_step_q};
		end else begin
			ref_toward = ref_q - {{(REF_W-STEP_W){1'b0}}, ramp_step_q};
		end
	end

	always_comb begin
		phase_d  = phase_q;
		timer_d  = timer_q;
		stable_d = stable_q;
		ref_d    = ref_q;
		loop_d   = loop_q;
		case (phase_q)
			PH_INIT: begin
				loop_d  = 1'b0;
				ref_d   = '0;
				phase_d = item_s1.fault_active ? PH_FAULT : PH_STANDBY;
			end
			PH_FAULT: begin
				loop_d = 1'b0;
				ref_d  = '0;
				if (!item_s1.fault_active) begin
					phase_d = PH_STANDBY;
					timer_d = '0;
				end
			end
			PH_STANDBY: begin
				if (item_s1.fault_active) begin
					loop_d  = 1'b0;
					ref_d   = '0;
					phase_d = PH_FAULT;
				end else if (item_s1.enable) begin
					phase_d = PH_PREPARE;
					timer_d = '0;
				end
			end
			PH_PREPARE: begin
				if (item_s1.fault_active) begin
					loop_d  = 1'b0;
					ref_d   = '0;
					phase_d = PH_FAULT;
				end else if (!item_s1.enable) begin
					phase_d = PH_STANDBY;
					timer_d = '0;
				end else if (timer_inc >= {{(TIMER_W-8){1'b0}}, prepare_ticks_q}) begin
					phase_d  = PH_SOFTSTART;
					timer_d  = '0;
					stable_d = '0;
					loop_d   = 1'b1;
				end else begin
					timer_d = timer_inc;
				end
			end
			PH_SOFTSTART: begin
				if (item_s1.fault_active) begin
					loop_d  = 1'b0;
					ref_d   = '0;
					phase_d = PH_FAULT;
				end else if (!item_s1.enable) begin
					phase_d = PH_STOPPING;
					timer_d = '0;
				end else begin
					timer_d = timer_inc;
					ref_d   = ref_toward;
					if (near) begin
						stable_d = stable_inc;
						if (stable_inc >= stable_ticks_q) begin
							phase_d = PH_RUN;
							timer_d = '0;
						end
					end else begin
						stable_d = '0;
					end
				end
			end
			PH_RUN: begin
				if (item_s1.fault_active) begin
					loop_d  = 1'b0;
					ref_d   = '0;
					phase_d = PH_FAULT;
				end else if (!item_s1.enable) begin
					phase_d = PH_STOPPING;
					timer_d = '0;
				end else if (!near) begin
					phase_d  = PH_SOFTSTART;
					timer_d  = '0;
					stable_d = '0;
				end
			end
			PH_STOPPING: begin
				loop_d = 1'b0;
				ref_d  = '0;
				if (item_s1.fault_active) begin
					phase_d = PH_FAULT;
				end else if (timer_inc >= stop_ticks_q) begin
					phase_d = PH_STANDBY;
					timer_d = '0;
				end else begin
					timer_d = timer_inc;
				end
			end
			default: begin
				loop_d  = 1'b0;
				ref_d   = '0;
				phase_d = PH_FAULT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_INIT;
			timer_q  <= '0;
			stable_q <= '0;
			ref_q    <= '0;
			loop_q   <= 1'b0;
		end else if (advance) begin
			phase_q  <= phase_d;
			timer_q  <= timer_d;
			stable_q <= stable_d;
			ref_q    <= ref_d;
			loop_q   <= loop_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.phase     <= phase_d;
			out_data_q.loop_on   <= loop_d;
			out_data_q.ref_value <= ref_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`ASSERT_HOLDS(a_loop_phase, !loop_q || (phase_q >= PH_SOFTSTART && phase_q <= PH_STOPPING))
	`ASSERT_HOLDS(a_fault_is_safe, phase_q != PH_FAULT || (!loop_q && ref_q == '0))
	`ASSERT_NEXT(a_advance_fills_result, advance, out_valid_q)
	`ASSERT_NEXT(a_ref_holds_when_idle, !advance, $stable(ref_q) && $stable(phase_q))

endmodule

`default_nettype wire

FILE: test/converter_softstart_sequencer_unit_test.sv
// ----------------------------------------------------------------------------
// converter_softstart_sequencer_unit_test
// drives slow ticks through the soft-start sequencer under several register
// settings and compares every result with a cycle-free model of the sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module converter_softstart_sequencer_unit_test;

	import cssq_pkg::*;

	localparam logic [REF_W-1:0] REF_MAX = '1;
	localparam int LIMIT     = 200000;
	localparam int HOLD_AT   = 200;
	localparam int LONG_HOLD = 50;
	localparam int CALM_FROM = 950;

	class softstart_scoreboard;
		logic [7:0]       prep_lim;
		logic [7:0]       stable_lim;
		logic [15:0]      stop_lim;
		logic [15:0]      step_sz;
		phase_t           ph;
		logic [15:0]      timer;
		logic [7:0]       stable_cnt;
		logic [REF_W-1:0] ramp_r;
		logic             loop_r;
		out_item_t        expected_q[$];
		int               errors;
		int               checked;
		bit [7:0]         phases_seen;

		function new();
			prep_lim    = PREPARE_TICKS_RST;
			stable_lim  = STABLE_TICKS_RST;
			stop_lim    = STOP_TICKS_RST;
			step_sz     = RAMP_STEP_RST;
			ph          = PH_INIT;
			timer       = '0;
			stable_cnt  = '0;
			ramp_r      = '0;
			loop_r      = 1'b0;
			errors      = 0;
			checked     = 0;
			phases_seen = '0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_PREPARE_TICKS: prep_lim   = data[7:0];
				CFG_STABLE_TICKS:  stable_lim = data[7:0];
				CFG_STOP_TICKS:    stop_lim   = data[15:0];
				CFG_RAMP_STEP:     step_sz    = data[STEP_W-1:0];
				default:           ;
			endcase
		endfunction

		function void shut_down();
			loop_r = 1'b0;
			ramp_r = '0;
		endfunction

		function void bump_timer();
			if (timer != 16'hffff)
				timer = timer + 16'd1;
		endfunction

		function logic [REF_W-1:0] ref_gap(input logic [REF_W-1:0] tgt);
			return (ramp_r >= tgt) ? ramp_r - tgt : tgt - ramp_r;
		endfunction

		// one step toward the target, snapping when within a step
		function bit ramp_to(input logic [REF_W-1:0] tgt);
			logic [REF_W-1:0] stp;
			stp = {{(REF_W-STEP_W){1'b0}}, step_sz};
			if (ref_gap(tgt) <= stp) begin
				ramp_r = tgt;
				return 1'b1;
			end
			if (ramp_r < tgt)
				ramp_r = ramp_r + stp;
			else
				ramp_r = ramp_r - stp;
			return 1'b0;
		endfunction

		function void note_tick(input in_item_t t);
			out_item_t o;
			if (ph == PH_INIT) begin
				shut_down();
				ph = t.fault_active ? PH_FAULT : PH_STANDBY;
			end else if (ph == PH_FAULT) begin
				shut_down();
				if (!t.fault_active) begin
					ph = PH_STANDBY;
					timer = '0;
				end
			end else if (t.fault_active) begin
				shut_down();
				ph = PH_FAULT;
			end else begin
				case (ph)
					PH_STANDBY: begin
						if (t.enable) begin
							ph = PH_PREPARE;
							timer = '0;
						end
					end
					PH_PREPARE: begin
						if (!t.enable) begin
							ph = PH_STANDBY;
							timer = '0;
						end else begin
							bump_timer();
							if (timer >= {8'd0, prep_lim}) begin
								ph = PH_SOFTSTART;
								timer = '0;
								stable_cnt = '0;
								loop_r = 1'b1;
							end
						end
					end
					PH_SOFTSTART: begin
						if (!t.enable) begin
							ph = PH_STOPPING;
							timer = '0;
						end else begin
							bump_timer();
							if (ramp_to(t.target_ref)) begin
								if (stable_cnt != 8'hff)
									stable_cnt = stable_cnt + 8'd1;
								if (stable_cnt >= stable_lim) begin
									ph = PH_RUN;
									timer = '0;
								end
							end else begin
								stable_cnt = '0;
							end
						end
					end
					PH_RUN: begin
						if (!t.enable) begin
							ph = PH_STOPPING;
							timer = '0;
						end else if (ref_gap(t.target_ref) >
								{{(REF_W-STEP_W){1'b0}}, step_sz}) begin
							ph = PH_SOFTSTART;
							timer = '0;
							stable_cnt = '0;
						end
					end
					PH_STOPPING: begin
						shut_down();
						bump_timer();
						if (timer >= stop_lim) begin
							ph = PH_STANDBY;
							timer = '0;
						end
					end
					default: begin
						shut_down();
						ph = PH_FAULT;
					end
				endcase
			end
			o.phase     = ph;
			o.loop_on   = loop_r;
			o.ref_value = ramp_r;
			expected_q.push_back(o);
		endfunction

		function void check_result(input out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected: %p", $time, got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			checked++;
			phases_seen[want.phase] = 1'b1;
			if (got.phase !== want.phase) begin
				$display("%0t: phase mismatch: expected %0d, actual %0d",
					$time, want.phase, got.phase);
				errors++;
			end
			if (got.loop_on !== want.loop_on) begin
				$display("%0t: loop_on mismatch: expected %b, actual %b",
					$time, want.loop_on, got.loop_on);
				errors++;
			end
			if (got.ref_value !== want.ref_value) begin
				$display("%0t: ref_value mismatch: expected %h, actual %h",
					$time, want.ref_value, got.ref_value);
				errors++;
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	logic      cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	softstart_scoreboard sb = new();
	int ticks_sent = 0;
	int reg_sets   = 0;
	int cycle_cnt  = 0;
	bit calm       = 1'b0;
	bit hold_req   = 1'b0;

	converter_softstart_sequencer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// one tick transfer, with an optional idle burst ahead of it
	task automatic tick(input logic en, input logic flt, input logic [REF_W-1:0] tgt);
		in_item_t item;
		int gap;
		item.enable       = en;
		item.fault_active = flt;
		item.target_ref   = tgt;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_tick(item);
		ticks_sent++;
		if (ticks_sent == HOLD_AT)
			hold_req = 1'b1;
		if (ticks_sent == CALM_FROM)
			calm = 1'b1;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// upper byte of the 8-bit registers carries junk that must be dropped
	task automatic set_regs(input int prep, input int stab, input int stop_len, input int stp);
		logic [CFG_DATA_W-1:0] w [4];
		logic [CFG_IDX_W-1:0]  idx [4];
		logic [7:0] junk;
		settle();
		junk = 8'($urandom);
		w[0] = {junk, prep[7:0]};
		junk = 8'($urandom);
		w[1] = {junk, stab[7:0]};
		w[2] = stop_len[15:0];
		w[3] = stp[15:0];
		idx[0] = CFG_PREPARE_TICKS;
		idx[1] = CFG_STABLE_TICKS;
		idx[2] = CFG_STOP_TICKS;
		idx[3] = CFG_RAMP_STEP;
		for (int i = 0; i < 4; i++) begin
			cfg_wen   <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= w[i];
			@(posedge clk);
			sb.set_reg(idx[i], w[i]);
		end
		cfg_wen <= 1'b0;
		reg_sets++;
	endtask

	function automatic logic [REF_W-1:0] pick_target(input int stp);
		logic [31:0] lvl;
		lvl = $urandom;
		if ($urandom_range(0, 9) == 0)
			return lvl[REF_W-1:0];
		if ($urandom_range(0, 19) == 0)
			return REF_MAX;
		lvl = $urandom_range(0, 12) * stp + $urandom_range(0, stp);
		return lvl[REF_W-1:0];
	endfunction

	// mostly complete start / run / stop sessions, some faults and noise
	task automatic run_phase(input int prep, input int stab, input int stop_len,
			input int stp, input int n_ticks);
		int stop_at;
		int pick;
		int on_len;
		int off_len;
		int flt_at;
		int shift_at;
		logic [REF_W-1:0] tgt;
		logic [31:0] raw;
		set_regs(prep, stab, stop_len, stp);
		stop_at = ticks_sent + n_ticks;
		while (ticks_sent < stop_at) begin
			pick = $urandom_range(0, 19);
			if (pick < 14) begin
				tgt = pick_target(stp);
				on_len = prep + stab + 16 + $urandom_range(0, 15);
				flt_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, on_len) : -1;
				shift_at = ($urandom_range(0, 2) == 0) ?
					$urandom_range(prep + stab + 14, on_len) : -1;
				for (int i = 0; i < on_len && ticks_sent < stop_at; i++) begin
					if (i == shift_at)
						tgt = pick_target(stp);
					tick(1'b1, i == flt_at, tgt);
				end
				off_len = ((stop_len > 40) ? 40 : stop_len) + $urandom_range(0, 4);
				for (int i = 0; i < off_len && ticks_sent < stop_at; i++) begin
					raw = $urandom;
					tick(1'b0, 1'b0, raw[REF_W-1:0]);
				end
				if (stop_len > 40 && ticks_sent < stop_at)
					tick(1'b0, 1'b1, '0);
			end else if (pick < 17) begin
				for (int i = $urandom_range(1, 3); i > 0 && ticks_sent < stop_at; i--) begin
					raw = $urandom;
					tick(raw[31], 1'b1, raw[REF_W-1:0]);
				end
				tick(1'b0, 1'b0, '0);
			end else begin
				for (int i = $urandom_range(1, 8); i > 0 && ticks_sent < stop_at; i--) begin
					raw = $urandom;
					tick(raw[31], raw[30], raw[REF_W-1:0]);
				end
			end
		end
	endtask

	initial begin
		int stall_left;
		bit held;
		stall_left = 0;
		held = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_result(out_data);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (hold_req && !held) begin
				held = 1'b1;
				stall_left = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 3);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_wen   <= 1'b0;
		cfg_index <= CFG_PREPARE_TICKS;
		cfg_wdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: init into fault, fault hold, standby
		tick(1'b0, 1'b1, '0);
		tick(1'b1, 1'b1, REF_MAX);
		tick(1'b0, 1'b0, REF_MAX);
		tick(1'b0, 1'b0, '0);

		set_regs(1, 1, 2, 65535);
		// start, run at zero, step-wide tolerance, fall back and ramp again
		tick(1'b1, 1'b0, REF_MAX);
		tick(1'b1, 1'b0, REF_MAX);
		tick(1'b1, 1'b0, '0);
		tick(1'b1, 1'b0, 25'd65535);
		tick(1'b1, 1'b0, 25'd65536);
		tick(1'b1, 1'b0, 25'd65536);
		tick(1'b1, 1'b0, 25'd65536);
		// stop timeout back to standby
		tick(1'b0, 1'b0, 25'd65536);
		tick(1'b0, 1'b0, '0);
		tick(1'b0, 1'b0, '0);
		// fault during soft start, in standby and in stopping
		tick(1'b1, 1'b0, REF_MAX);
		tick(1'b1, 1'b0, REF_MAX);
		tick(1'b1, 1'b0, REF_MAX);
		tick(1'b1, 1'b1, REF_MAX);
		tick(1'b1, 1'b0, '0);
		tick(1'b1, 1'b1, '0);
		tick(1'b0, 1'b0, '0);
		tick(1'b1, 1'b0, '0);
		tick(1'b0, 1'b0, '0);
		tick(1'b1, 1'b0, '0);
		tick(1'b1, 1'b0, '0);
		tick(1'b0, 1'b0, '0);
		tick(1'b1, 1'b1, '0);
		tick(1'b0, 1'b0, '0);

		run_phase(255, 3, 2, 20000, 250);
		run_phase(1, 255, 65535, 65535, 320);
		run_phase(0, 0, 0, 0, 100);
		run_phase(4, 6, 12, 1, 150);
		run_phase(2, 2, 5, 3000, 250);

		settle();
		repeat (6) @(posedge clk);
		$display("%0d ticks over %0d register settings, %0d results checked",
			ticks_sent, reg_sets, sb.checked);
		$display("phase codes reached (bit per code): %b", sb.phases_seen);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d errors, %0d results missing", sb.errors, sb.expected_q.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
